[sv/cnv_pkg.sv]
// Package for the multi-kernel 2-D convolution sum block.
// Holds limits, payload structs and register codes; depends on nothing.
package cnv_pkg;

  localparam int MAX_KERNELS     = 4;
  localparam int MAX_KERNEL_SIZE = 5;
  localparam int MAX_LINE        = 1024;

  localparam int PIX_W  = 16;
  localparam int SUM_W  = 40;
  localparam int PROD_W = 32;
  localparam int ROW_W  = 16;
  localparam int COL_W  = 10;
  localparam int CFG_W  = 16;

  localparam logic [9:0]  FW_RST = 10'd64;
  localparam logic [15:0] FH_RST = 16'd64;
  localparam logic [2:0]  KC_RST = 3'd1;
  localparam logic [2:0]  KS_RST = 3'd3;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_KERNEL_COUNT = 2'd2,
    REG_KERNEL_SIZE  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              func;
    logic [1:0]        kernel_sel;
    logic [4:0]        tap_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] conv_sum;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic                    frame_end;
  } out_item_t;

endpackage

[sv/multi_kernel_conv2d_sum_top.sv]
// Top level of the multi-kernel 2-D convolution sum block.
// Uses cnv_pkg for types and limits, and cnv_ram for the line store.
//
//  channel | ports                         | transfer when
//  --------+-------------------------------+-------------------------
//  input   | in_valid, in_ready, in_data   | in_valid & in_ready
//  result  | out_valid, out_ready, out_data| out_valid & out_ready
//  config  | cfg_we, cfg_addr, cfg_wdata   | cfg_we
//
// One item a cycle while in_ready is high. The line store read in the
// accept cycle and its write-back in the next cycle set the pace, with
// a forward of the last write-back for narrow rows.
// After reset every line store address is cleared, with in_ready low.
// A result queue of eight entries absorbs output stalls; after the clear,
// in_ready drops only when results in flight would overrun it.
module multi_kernel_conv2d_sum_top #(
  parameter int MAX_KERNELS     = cnv_pkg::MAX_KERNELS,
  parameter int MAX_KERNEL_SIZE = cnv_pkg::MAX_KERNEL_SIZE,
  parameter int MAX_LINE        = cnv_pkg::MAX_LINE
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cnv_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cnv_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [cnv_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int PW        = cnv_pkg::PIX_W;
  localparam int SW        = cnv_pkg::SUM_W;
  localparam int MKS       = MAX_KERNEL_SIZE;
  localparam int MK        = MAX_KERNELS;
  localparam int LINE_ROWS = (MKS > 1) ? MKS - 1 : 1;
  localparam int LW        = LINE_ROWS * PW;
  localparam int AW        = $clog2(MAX_LINE);
  localparam int KSW       = $clog2(MKS + 1);
  localparam int KIW       = (MKS > 1) ? $clog2(MKS) : 1;
  localparam int KLW       = (MK > 1) ? $clog2(MK) : 1;
  localparam int KCW       = $clog2(MK + 1);
  localparam int RW        = 17;
  localparam int FIFO_D    = 8;
  localparam int FPW       = $clog2(FIFO_D);
  localparam int FCW       = $clog2(FIFO_D + 1);

  // configuration registers
  logic [9:0]  fw_r;
  logic [15:0] fh_r;
  logic [2:0]  kc_r;
  logic [2:0]  ks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= cnv_pkg::FW_RST;
      fh_r <= cnv_pkg::FH_RST;
      kc_r <= cnv_pkg::KC_RST;
      ks_r <= cnv_pkg::KS_RST;
    end else if (cfg_we) begin
      case (cnv_pkg::cfg_reg_t'(cfg_addr))
        cnv_pkg::REG_FRAME_WIDTH:  fw_r <= cfg_wdata[9:0];
        cnv_pkg::REG_FRAME_HEIGHT: fh_r <= cfg_wdata[15:0];
        cnv_pkg::REG_KERNEL_COUNT: kc_r <= cfg_wdata[2:0];
        cnv_pkg::REG_KERNEL_SIZE:  ks_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [KSW-1:0] ks_sat, ks_eff, step;
  logic [RW-1:0]  two_step, fw0, fw_lim, fwc, pw, fh0, ph;
  logic [KCW-1:0] kc_eff;

  always_comb begin
    if (int'(ks_r) > MKS) ks_sat = KSW'(MKS);
    else                  ks_sat = KSW'(ks_r);
    if (ks_sat[0]) ks_eff = ks_sat;
    else if (ks_sat == '0) ks_eff = KSW'(1);
    else ks_eff = ks_sat - KSW'(1);
    step     = (ks_eff - KSW'(1)) >> 1;
    two_step = RW'(step) << 1;
    fw0      = (fw_r == '0) ? RW'(1) : RW'(fw_r);
    fw_lim   = RW'(MAX_LINE) - two_step;
    fwc      = (fw0 > fw_lim) ? fw_lim : fw0;
    pw       = fwc + two_step;
    fh0      = (fh_r == '0) ? RW'(1) : RW'(fh_r);
    ph       = fh0 + two_step;
    if (int'(kc_r) > MK) kc_eff = KCW'(MK);
    else                 kc_eff = KCW'(kc_r);
  end

  // position and input decode
  logic [RW-1:0] rpos_r, rpos_nxt;
  logic [AW-1:0] cpos_r, cpos_nxt;
  logic [RW-1:0] cur_r, cur_c;
  logic          border, has_res, is_end, acc, pix_acc;
  logic [KIW-1:0] crow, ccol;
  logic           ld_ok;
  logic signed [PW-1:0] pix_val;

  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic [FCW-1:0] cred_r;

  assign in_ready = !clr_busy_r && (cred_r < FCW'(FIFO_D));
  assign acc      = in_valid && in_ready;
  assign pix_acc  = acc && (in_data.func == cnv_pkg::FUNC_PIXEL);

  always_comb begin
    cur_r = rpos_r;
    cur_c = RW'(cpos_r);
    if (rpos_r >= ph || RW'(cpos_r) >= pw) begin
      cur_r = '0;
      cur_c = '0;
    end
    border = (cur_r < RW'(step)) || (cur_r >= RW'(step) + fh0) ||
             (cur_c < RW'(step)) || (cur_c >= RW'(step) + fwc);
    pix_val = border ? '0 : in_data.pixel;
    has_res = (cur_r >= two_step) && (cur_c >= two_step);
    is_end  = (cur_r == ph - RW'(1)) && (cur_c == pw - RW'(1));
    if (cur_c + RW'(1) >= pw) begin
      cpos_nxt = '0;
      rpos_nxt = (cur_r + RW'(1) >= ph) ? '0 : cur_r + RW'(1);
    end else begin
      cpos_nxt = AW'(cur_c + RW'(1));
      rpos_nxt = cur_r;
    end
    // split tap index into row and column of the kernel
    crow = '0;
    for (int k = 1; k < MKS; k++) begin
      if (k * int'(ks_eff) <= int'(in_data.tap_index)) crow = crow + KIW'(1);
    end
    ccol  = KIW'(int'(in_data.tap_index) - int'(crow) * int'(ks_eff));
    ld_ok = (int'(in_data.kernel_sel) < MK) &&
            (int'(in_data.tap_index) < int'(ks_eff) * int'(ks_eff));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      rpos_r <= '0;
      cpos_r <= '0;
    end else if (pix_acc) begin
      rpos_r <= rpos_nxt;
      cpos_r <= cpos_nxt;
    end
  end

  // stage 1: line store data arrives
  logic                 p1_vld_r, p1_pix_r, p1_ldok_r, p1_res_r, p1_end_r;
  logic [KLW-1:0]       p1_ksel_r;
  logic [KIW-1:0]       p1_crow_r, p1_ccol_r;
  logic signed [PW-1:0] p1_coef_r, p1_val_r;
  logic [AW-1:0]        p1_col_r;
  logic [15:0]          p1_orow_r;
  logic [9:0]           p1_ocol_r;
  logic [KSW-1:0]       p1_ks_r;
  logic [KCW-1:0]       p1_kc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= acc;
    end
    p1_pix_r  <= (in_data.func == cnv_pkg::FUNC_PIXEL);
    p1_ldok_r <= ld_ok;
    p1_res_r  <= has_res;
    p1_end_r  <= is_end;
    p1_ksel_r <= KLW'(in_data.kernel_sel);
    p1_crow_r <= crow;
    p1_ccol_r <= ccol;
    p1_coef_r <= in_data.coef_value;
    p1_val_r  <= pix_val;
    p1_col_r  <= AW'(cur_c);
    p1_orow_r <= 16'(cur_r - two_step);
    p1_ocol_r <= 10'(cur_c - two_step);
    p1_ks_r   <= ks_eff;
    p1_kc_r   <= kc_eff;
  end

  logic [LW-1:0] ram_q, line_w, line_new;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic          fwd_vld_r;
  logic [AW-1:0] fwd_addr_r;
  logic [LW-1:0] fwd_data_r;

  cnv_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_LINE)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(cur_c)),
    .rdata (ram_q)
  );

  logic signed [PW-1:0] colv [MKS];
  logic signed [PW-1:0] win_r [MKS][MKS];
  logic signed [PW-1:0] win_nxt [MKS][MKS];

  always_comb begin
    // take the previous write-back when it hit this column
    line_w = (fwd_vld_r && fwd_addr_r == p1_col_r) ? fwd_data_r : ram_q;
    for (int j = 0; j < MKS; j++) begin
      if (j + 1 < int'(p1_ks_r)) colv[j] = line_w[PW*(int'(p1_ks_r) - 2 - j) +: PW];
      else if (j + 1 == int'(p1_ks_r)) colv[j] = p1_val_r;
      else colv[j] = '0;
    end
    line_new = line_w << PW;
    line_new[PW-1:0] = p1_val_r;
    for (int i = 0; i < MKS; i++) begin
      for (int j = 0; j < MKS; j++) begin
        if (i < int'(p1_ks_r) && j + 1 < int'(p1_ks_r)) win_nxt[i][j] = win_r[i][(j+1)%MKS];
        else if (i < int'(p1_ks_r) && j + 1 == int'(p1_ks_r)) win_nxt[i][j] = colv[i];
        else win_nxt[i][j] = win_r[i][j];
      end
    end
    ram_we    = clr_busy_r || (p1_vld_r && p1_pix_r);
    ram_waddr = clr_busy_r ? clr_addr_r : p1_col_r;
    ram_wdata = clr_busy_r ? '0 : line_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      fwd_vld_r  <= 1'b0;
      for (int i = 0; i < MKS; i++) begin
        for (int j = 0; j < MKS; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_LINE - 1)) clr_busy_r <= 1'b0;
      end
      fwd_vld_r <= p1_vld_r && p1_pix_r;
      if (p1_vld_r && p1_pix_r) win_r <= win_nxt;
    end
    fwd_addr_r <= p1_col_r;
    fwd_data_r <= line_new;
  end

  // stage 2: multiply, and coefficient writes in item order
  logic                 p2_vld_r, p2_pix_r, p2_ldok_r, p2_res_r, p2_end_r;
  logic [KLW-1:0]       p2_ksel_r;
  logic [KIW-1:0]       p2_crow_r, p2_ccol_r;
  logic signed [PW-1:0] p2_coef_r;
  logic [15:0]          p2_orow_r;
  logic [9:0]           p2_ocol_r;
  logic [KSW-1:0]       p2_ks_r;
  logic [KCW-1:0]       p2_kc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
    p2_pix_r  <= p1_pix_r;
    p2_ldok_r <= p1_ldok_r;
    p2_res_r  <= p1_res_r;
    p2_end_r  <= p1_end_r;
    p2_ksel_r <= p1_ksel_r;
    p2_crow_r <= p1_crow_r;
    p2_ccol_r <= p1_ccol_r;
    p2_coef_r <= p1_coef_r;
    p2_orow_r <= p1_orow_r;
    p2_ocol_r <= p1_ocol_r;
    p2_ks_r   <= p1_ks_r;
    p2_kc_r   <= p1_kc_r;
  end

  logic signed [PW-1:0] coef_r [MK][MKS][MKS];

  always_ff @(posedge clk) begin
    if (p2_vld_r && !p2_pix_r && p2_ldok_r) begin
      coef_r[p2_ksel_r][p2_crow_r][p2_ccol_r] <= p2_coef_r;
    end
  end

  logic signed [cnv_pkg::PROD_W-1:0] prod_r [MK][MKS][MKS];
  logic p3_vld_r, p3_end_r;
  logic [15:0] p3_orow_r;
  logic [9:0]  p3_ocol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= p2_vld_r && p2_pix_r && p2_res_r;
    end
    p3_end_r  <= p2_end_r;
    p3_orow_r <= p2_orow_r;
    p3_ocol_r <= p2_ocol_r;
    for (int l = 0; l < MK; l++) begin
      for (int i = 0; i < MKS; i++) begin
        for (int j = 0; j < MKS; j++) begin
          if (l < int'(p2_kc_r) && i < int'(p2_ks_r) && j < int'(p2_ks_r))
            prod_r[l][i][j] <= win_r[i][j] * coef_r[l][i][j];
          else
            prod_r[l][i][j] <= '0;
        end
      end
    end
  end

  // stages 3 to 5: adder tree
  logic signed [SW-1:0] rsum [MK][MKS];
  logic signed [SW-1:0] rsum_r [MK][MKS];
  logic signed [SW-1:0] ksum [MK];
  logic signed [SW-1:0] ksum_r [MK];
  logic signed [SW-1:0] total;
  logic p4_vld_r, p4_end_r, p5_vld_r, p5_end_r;
  logic [15:0] p4_orow_r, p5_orow_r;
  logic [9:0]  p4_ocol_r, p5_ocol_r;

  always_comb begin
    for (int l = 0; l < MK; l++) begin
      for (int i = 0; i < MKS; i++) begin
        rsum[l][i] = '0;
        for (int j = 0; j < MKS; j++) rsum[l][i] = rsum[l][i] + SW'(prod_r[l][i][j]);
      end
      ksum[l] = '0;
      for (int i = 0; i < MKS; i++) ksum[l] = ksum[l] + rsum_r[l][i];
    end
    total = '0;
    for (int l = 0; l < MK; l++) total = total + ksum_r[l];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
      p5_vld_r <= 1'b0;
    end else begin
      p4_vld_r <= p3_vld_r;
      p5_vld_r <= p4_vld_r;
    end
    rsum_r    <= rsum;
    ksum_r    <= ksum;
    p4_end_r  <= p3_end_r;
    p4_orow_r <= p3_orow_r;
    p4_ocol_r <= p3_ocol_r;
    p5_end_r  <= p4_end_r;
    p5_orow_r <= p4_orow_r;
    p5_ocol_r <= p4_ocol_r;
  end

  // result queue and credit count
  cnv_pkg::out_item_t fifo_r [FIFO_D];
  cnv_pkg::out_item_t push_item;
  logic [FPW-1:0] wp_r, rp_r;
  logic [FCW-1:0] fcnt_r;
  logic           pop, cred_inc;

  assign out_valid = (fcnt_r != '0);
  assign out_data  = fifo_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign cred_inc  = pix_acc && has_res;

  always_comb begin
    push_item.conv_sum  = total;
    push_item.out_row   = p5_orow_r;
    push_item.out_col   = p5_ocol_r;
    push_item.frame_end = p5_end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fcnt_r <= '0;
      cred_r <= '0;
    end else begin
      if (p5_vld_r) wp_r <= wp_r + FPW'(1);
      if (pop)      rp_r <= rp_r + FPW'(1);
      fcnt_r <= fcnt_r + FCW'(p5_vld_r) - FCW'(pop);
      cred_r <= cred_r + FCW'(cred_inc) - FCW'(pop);
    end
    if (p5_vld_r) fifo_r[wp_r] <= push_item;
  end

endmodule

[sv/cnv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Read returns the old data when read and write hit the same address.
module cnv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[test/tb_multi_kernel_conv2d_sum_top.sv]
// Testbench for multi_kernel_conv2d_sum_top: random and directed frames,
// checked against a cycle-free predictor held in a small scoreboard class.
// Depends on cnv_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_multi_kernel_conv2d_sum_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 24;
  localparam int TAPS = cnv_pkg::MAX_KERNEL_SIZE * cnv_pkg::MAX_KERNEL_SIZE;

  class conv_scoreboard;
    int coef [cnv_pkg::MAX_KERNELS][TAPS];
    int line_mem [cnv_pkg::MAX_KERNEL_SIZE-1][cnv_pkg::MAX_LINE];
    int win [cnv_pkg::MAX_KERNEL_SIZE][cnv_pkg::MAX_KERNEL_SIZE];
    logic [9:0]  width_reg;
    logic [15:0] height_reg;
    logic [2:0]  count_reg;
    logic [2:0]  size_reg;
    int row_pos, col_pos;
    cnv_pkg::out_item_t pending_results[$];
    int errors;

    function void clear();
      foreach (coef[k, t]) coef[k][t] = 0;
      foreach (line_mem[d, c]) line_mem[d][c] = 0;
      foreach (win[i, j]) win[i][j] = 0;
      width_reg = cnv_pkg::FW_RST;
      height_reg = cnv_pkg::FH_RST;
      count_reg = cnv_pkg::KC_RST;
      size_reg = cnv_pkg::KS_RST;
      row_pos = 0;
      col_pos = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void write_reg(cnv_pkg::cfg_reg_t idx, logic [cnv_pkg::CFG_W-1:0] val);
      case (idx)
        cnv_pkg::REG_FRAME_WIDTH:  width_reg = val[9:0];
        cnv_pkg::REG_FRAME_HEIGHT: height_reg = val[15:0];
        cnv_pkg::REG_KERNEL_COUNT: count_reg = val[2:0];
        cnv_pkg::REG_KERNEL_SIZE:  size_reg = val[2:0];
        default: ;
      endcase
      row_pos = 0;
      col_pos = 0;
    endfunction

    function void note_input(cnv_pkg::in_item_t it);
      int ks, stp, fw, fh, kc, pw, ph, r, c, pix, tap;
      int colv [cnv_pkg::MAX_KERNEL_SIZE];
      longint acc;
      cnv_pkg::out_item_t res;
      ks = (size_reg > cnv_pkg::MAX_KERNEL_SIZE) ? cnv_pkg::MAX_KERNEL_SIZE : size_reg;
      if (ks % 2 == 0) ks = (ks == 0) ? 1 : ks - 1;
      stp = (ks - 1) / 2;
      fw = (width_reg == 0) ? 1 : width_reg;
      fh = (height_reg == 0) ? 1 : height_reg;
      kc = (count_reg > cnv_pkg::MAX_KERNELS) ? cnv_pkg::MAX_KERNELS : count_reg;
      if (fw > cnv_pkg::MAX_LINE - 2 * stp) fw = cnv_pkg::MAX_LINE - 2 * stp;
      pw = fw + 2 * stp;
      ph = fh + 2 * stp;
      if (it.func == cnv_pkg::FUNC_LOAD) begin
        tap = it.tap_index;
        if (tap < ks * ks)
          coef[it.kernel_sel][(tap / ks) * cnv_pkg::MAX_KERNEL_SIZE + tap % ks] =
              it.coef_value;
        return;
      end
      r = row_pos;
      c = col_pos;
      if (r >= ph || c >= pw) begin
        r = 0;
        c = 0;
      end
      pix = it.pixel;
      // border band is zero whatever the pixel says
      if (r < stp || r >= stp + fh || c < stp || c >= stp + fw) pix = 0;
      colv[ks-1] = pix;
      for (int j = 0; j + 1 < ks; j++) colv[j] = line_mem[ks-2-j][c];
      for (int d = cnv_pkg::MAX_KERNEL_SIZE - 2; d > 0; d--) line_mem[d][c] = line_mem[d-1][c];
      line_mem[0][c] = pix;
      for (int i = 0; i < ks; i++) begin
        for (int j = 0; j + 1 < ks; j++) win[i][j] = win[i][j+1];
        win[i][ks-1] = colv[i];
      end
      if (r >= 2 * stp && c >= 2 * stp) begin
        acc = 0;
        for (int k = 0; k < kc; k++)
          for (int i = 0; i < ks; i++)
            for (int j = 0; j < ks; j++)
              acc += longint'(win[i][j]) *
                     longint'(coef[k][i * cnv_pkg::MAX_KERNEL_SIZE + j]);
        res.conv_sum = acc[cnv_pkg::SUM_W-1:0];
        res.out_row = 16'(r - 2 * stp);
        res.out_col = 10'(c - 2 * stp);
        res.frame_end = (r == ph - 1 && c == pw - 1);
        pending_results.insert(pending_results.size(), res);
      end
      c++;
      if (c >= pw) begin
        c = 0;
        r++;
        if (r >= ph) r = 0;
      end
      row_pos = r;
      col_pos = c;
    endfunction

    task check_result(cnv_pkg::out_item_t got);
      cnv_pkg::out_item_t exp;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result row %0d col %0d", got.out_row, got.out_col));
        return;
      end
      exp = pending_results.pop_front();
      if (got.conv_sum !== exp.conv_sum)
        report($sformatf("conv_sum %0d, want %0d (row %0d col %0d)",
                         got.conv_sum, exp.conv_sum, exp.out_row, exp.out_col));
      if (got.out_row !== exp.out_row)
        report($sformatf("out_row %0d, want %0d", got.out_row, exp.out_row));
      if (got.out_col !== exp.out_col)
        report($sformatf("out_col %0d, want %0d", got.out_col, exp.out_col));
      if (got.frame_end !== exp.frame_end)
        report($sformatf("frame_end %0b, want %0b (row %0d col %0d)",
                         got.frame_end, exp.frame_end, exp.out_row, exp.out_col));
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  cnv_pkg::in_item_t in_data;
  cnv_pkg::out_item_t out_data;
  logic cfg_we;
  logic [1:0] cfg_addr;
  logic [cnv_pkg::CFG_W-1:0] cfg_wdata;

  conv_scoreboard sb;
  bit no_idle;
  int cycles;
  int pixel_total;

  multi_kernel_conv2d_sum_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= no_idle || ($urandom_range(99) >= 17);

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);

  function bit take_gap();
    return !no_idle && ($urandom_range(99) < 17);
  endfunction

  // leaves valid high after the transfer; a gap in the next call or a drain lowers it
  task automatic send(cnv_pkg::in_item_t it);
    @(negedge clk);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    if (it.func == cnv_pkg::FUNC_PIXEL) pixel_total++;
  endtask

  task automatic send_load(int ksel, int tap, int val);
    cnv_pkg::in_item_t it;
    it = cnv_pkg::in_item_t'($bits(cnv_pkg::in_item_t)'({$urandom, $urandom}));
    it.func = cnv_pkg::FUNC_LOAD;
    it.kernel_sel = 2'(ksel);
    it.tap_index = 5'(tap);
    it.coef_value = 16'(val);
    send(it);
  endtask

  task automatic send_pixel(int val);
    cnv_pkg::in_item_t it;
    it = cnv_pkg::in_item_t'($bits(cnv_pkg::in_item_t)'({$urandom, $urandom}));
    it.func = cnv_pkg::FUNC_PIXEL;
    it.pixel = 16'(val);
    send(it);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int kc, int ks);
    logic [cnv_pkg::CFG_W-1:0] vals [4];
    drain();
    // random upper bits on the narrow registers; only the low bits count
    vals[0] = {6'($urandom_range(63)), w[9:0]};
    vals[1] = h[15:0];
    vals[2] = {13'($urandom_range(8191)), kc[2:0]};
    vals[3] = {13'($urandom_range(8191)), ks[2:0]};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= i[1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(cnv_pkg::cfg_reg_t'(i), vals[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function int rand_pixel();
    case ($urandom_range(9))
      0: return 32767;
      1: return -32768;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic run_phase(int w, int h, int kc, int ks, int n);
    configure(w, h, kc, ks);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8)
        send_load($urandom_range(3), $urandom_range(31), $signed(16'($urandom)));
      else
        send_pixel(rand_pixel());
    end
  endtask

  initial begin
    int w, h;
    sb = new();
    sb.clear();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    cycles = 0;
    pixel_total = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // hold off until the line store clear is done
    @(posedge clk);
    wait (in_ready);

    // fill every coefficient slot at the widest layout
    configure(64, 64, 1, 5);
    for (int k = 0; k < cnv_pkg::MAX_KERNELS; k++)
      for (int t = 0; t < TAPS; t++)
        send_load(k, t, $signed(16'($urandom)));

    // tiny 2x2 frame, all kernels, extreme pixels and coefficients
    configure(2, 2, 4, 3);
    send_load(0, 9, 123);          // tap beyond the 3x3 kernel: drop
    send_load(3, 31, -5);
    send_load(0, 0, 32767);
    send_load(3, 8, -32768);
    for (int i = 0; i < 16; i++) begin
      if (i == 9) send_load(1, 4, -32768);  // load inside the frame
      send_pixel((i % 2) ? -32768 : 32767);
    end
    send_pixel(32767);             // wraps into the next frame

    // 1x1 kernel, no border, zero count gives zero sums
    run_phase(3, 2, 0, 1, 8);
    // even size rounds down, count above the limit saturates
    run_phase(0, 0, 7, 4, 12);
    // widest width the register holds, one long row, both sides never idle
    no_idle = 1'b1;
    run_phase(1023, 1, 2, 1, 1030);
    no_idle = 1'b0;
    run_phase(1020, 65535, 4, 7, 40);

    while (pixel_total < 1150) begin
      w = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 1020 : $urandom_range(1023))
                                   : $urandom_range(1, 10);
      h = ($urandom_range(19) == 0) ? ($urandom_range(1) ? 0 : 65535)
                                    : $urandom_range(1, 6);
      run_phase(w, h, $urandom_range(7), $urandom_range(7), $urandom_range(20, 160));
    end

    drain();
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[multi_kernel_conv2d_sum_top.f]
sv/cnv_pkg.sv
sv/cnv_ram.sv
sv/multi_kernel_conv2d_sum_top.sv
test/tb_multi_kernel_conv2d_sum_top.sv
